// ===== rtl/deq_pkg.sv =====
// Shared types and constants of the double-ended queue.
package deq_pkg;

	localparam int DATA_W  = 32;
	localparam int COUNT_W = 7;

	typedef enum logic [2:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_REAR  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_REAR   = 3'd3,
		CMD_DUMP       = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

endpackage

// ===== rtl/double_ended_queue.sv =====
// Double-ended queue top level: command sequencer, pointers and result register.
//
// A bounded deque of signed 32-bit words kept in one ring RAM of CAPACITY
// entries. Each item on the input stream carries a command in tuser (push
// front, push rear, pop front, pop rear, dump) and the word to push in tdata.
// Each command gives one result item with the status, the front and rear
// words and the element count after the command; a dump gives one result per
// stored word, front to rear, with tlast on the final one (an empty dump gives
// a single empty result). The front and rear words live in registers beside
// the RAM, so pushes need no read; a pop reads the new end word back from the
// RAM. The RAM's single registered read port shapes the steps when the output
// side is ready: a push, an unknown command, a pop on an empty queue or a
// pop that empties the queue goes through accept and execute, any other
// pop through accept, execute and issue read, take data, and a dump through
// accept, execute and issue read, then take data per stored word with a read
// between (accept, execute when empty). One command is in work at a time; a
// new command is accepted while the previous result still sits in the output
// register. A push on a full queue is dropped and flagged full; a pop on an
// empty queue is flagged empty and changes nothing.
module double_ended_queue #(
	parameter int CAPACITY = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [deq_pkg::DATA_W-1:0]  s_axis_tdata,   // [31:0] item_value
	input  logic [2:0]                  s_axis_tuser,   // [2:0] command
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [103:0]                m_axis_tdata,   // [31:0] dumped_value,
	                                                    // [63:32] front_value,
	                                                    // [95:64] rear_value,
	                                                    // [102:96] element_count,
	                                                    // [103] zero pad
	output logic [1:0]                  m_axis_tuser,   // [1:0] status
	output logic                        m_axis_tlast    // last result of a command
);

	import deq_pkg::*;

	localparam int                 IDX_W    = $clog2(CAPACITY);
	localparam logic [COUNT_W-1:0] CAP_C    = COUNT_W'(CAPACITY);
	localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(CAPACITY - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_POP_WAIT,
		S_DUMP_WAIT,
		S_DUMP_READ
	} state_t;

	function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
		return (i == LAST_IDX) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
		return (i == '0) ? LAST_IDX : i - 1'b1;
	endfunction

	state_t               state_q, state_d;
	cmd_t                 cmd_q;
	logic [DATA_W-1:0]    val_q;
	logic [IDX_W-1:0]     front_q, front_d;   // ring slot of the front word
	logic [IDX_W-1:0]     tail_q, tail_d;     // ring slot one past the rear word
	logic [COUNT_W-1:0]   count_q, count_d;
	logic [DATA_W-1:0]    fv_q, fv_d;         // front word shadow
	logic [DATA_W-1:0]    rv_q, rv_d;         // rear word shadow
	logic [IDX_W-1:0]     dump_ptr_q, dump_ptr_d;
	logic [COUNT_W-1:0]   dump_n_q, dump_n_d;

	logic                 out_valid_q;
	status_t              out_status_q;
	logic [DATA_W-1:0]    out_dumped_q, out_front_q, out_rear_q;
	logic [COUNT_W-1:0]   out_count_q;
	logic                 out_last_q;

	logic                 load_out;
	status_t              o_status;
	logic [DATA_W-1:0]    o_dumped;
	logic                 o_last;

	logic                 ram_we, ram_re;
	logic [IDX_W-1:0]     ram_waddr, ram_raddr;
	logic [DATA_W-1:0]    ram_wdata, ram_rdata;

	logic                 out_free, q_full, q_empty, in_accept;
	logic [IDX_W-1:0]     front_inc, front_dec, tail_inc, tail_dec, tail_dec2;

	deq_ram #(
		.WIDTH (DATA_W),
		.DEPTH (CAPACITY)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	// The result register can take a new item when empty or draining now.
	assign out_free      = !out_valid_q || m_axis_tready;
	assign q_full        = (count_q == CAP_C);
	assign q_empty       = (count_q == '0);

	assign front_inc = idx_inc(front_q);
	assign front_dec = idx_dec(front_q);
	assign tail_inc  = idx_inc(tail_q);
	assign tail_dec  = idx_dec(tail_q);
	assign tail_dec2 = idx_dec(tail_dec);

	always_comb begin
		state_d    = state_q;
		front_d    = front_q;
		tail_d     = tail_q;
		count_d    = count_q;
		fv_d       = fv_q;
		rv_d       = rv_q;
		dump_ptr_d = dump_ptr_q;
		dump_n_d   = dump_n_q;
		ram_we     = 1'b0;
		ram_waddr  = tail_q;
		ram_wdata  = val_q;
		ram_re     = 1'b0;
		ram_raddr  = front_q;
		load_out   = 1'b0;
		o_status   = ST_OK;
		o_dumped   = '0;
		o_last     = 1'b1;

		case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				// Hold the command until the result register has room.
				if (out_free) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
					case (cmd_q)
						CMD_PUSH_FRONT: begin
							if (q_full) begin
								o_status = ST_FULL;
							end else begin
								ram_we    = 1'b1;
								ram_waddr = front_dec;
								front_d   = front_dec;
								count_d   = count_q + 1'b1;
								fv_d      = val_q;
								if (q_empty) begin
									rv_d = val_q;
								end
							end
						end
						CMD_PUSH_REAR: begin
							if (q_full) begin
								o_status = ST_FULL;
							end else begin
								ram_we    = 1'b1;
								ram_waddr = tail_q;
								tail_d    = tail_inc;
								count_d   = count_q + 1'b1;
								rv_d      = val_q;
								if (q_empty) begin
									fv_d = val_q;
								end
							end
						end
						CMD_POP_FRONT: begin
							if (q_empty) begin
								o_status = ST_EMPTY;
							end else begin
								front_d = front_inc;
								count_d = count_q - 1'b1;
								// Fetch the new front word unless the queue drains.
								if (count_q != COUNT_W'(1)) begin
									load_out  = 1'b0;
									ram_re    = 1'b1;
									ram_raddr = front_inc;
									state_d   = S_POP_WAIT;
								end
							end
						end
						CMD_POP_REAR: begin
							if (q_empty) begin
								o_status = ST_EMPTY;
							end else begin
								tail_d  = tail_dec;
								count_d = count_q - 1'b1;
								if (count_q != COUNT_W'(1)) begin
									load_out  = 1'b0;
									ram_re    = 1'b1;
									ram_raddr = tail_dec2;
									state_d   = S_POP_WAIT;
								end
							end
						end
						CMD_DUMP: begin
							if (q_empty) begin
								o_status = ST_EMPTY;
							end else begin
								load_out   = 1'b0;
								ram_re     = 1'b1;
								ram_raddr  = front_q;
								dump_ptr_d = front_inc;
								dump_n_d   = '0;
								state_d    = S_DUMP_WAIT;
							end
						end
						default: begin
							o_status = ST_OK;
						end
					endcase
				end
			end
			S_POP_WAIT: begin
				// Result register was freed when the read was issued.
				load_out = 1'b1;
				state_d  = S_IDLE;
				if (cmd_q == CMD_POP_FRONT) begin
					fv_d = ram_rdata;
				end else begin
					rv_d = ram_rdata;
				end
			end
			S_DUMP_WAIT: begin
				load_out = 1'b1;
				o_dumped = ram_rdata;
				o_last   = (dump_n_q == count_q - 1'b1);
				state_d  = o_last ? S_IDLE : S_DUMP_READ;
			end
			S_DUMP_READ: begin
				if (out_free) begin
					ram_re     = 1'b1;
					ram_raddr  = dump_ptr_q;
					dump_ptr_d = idx_inc(dump_ptr_q);
					dump_n_d   = dump_n_q + 1'b1;
					state_d    = S_DUMP_WAIT;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			front_q     <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			tail_q  <= tail_d;
			count_q <= count_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: no reset needed.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_q <= cmd_t'(s_axis_tuser);
			val_q <= s_axis_tdata;
		end
		fv_q       <= fv_d;
		rv_q       <= rv_d;
		dump_ptr_q <= dump_ptr_d;
		dump_n_q   <= dump_n_d;
		if (load_out) begin
			out_status_q <= o_status;
			out_dumped_q <= o_dumped;
			out_front_q  <= (count_d == '0) ? '0 : fv_d;
			out_rear_q   <= (count_d == '0) ? '0 : rv_d;
			out_count_q  <= count_d;
			out_last_q   <= o_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_count_q, out_rear_q, out_front_q, out_dumped_q};
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tlast  = out_last_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("element count exceeds capacity");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_valid_q || m_axis_tready))
		else $error("result register overwritten while held");

	a_ring_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(q_empty || q_full) |-> (front_q == tail_q))
		else $error("front and tail pointers disagree with count");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && o_status == ST_EMPTY) |-> o_last)
		else $error("empty result not marked last");

	a_ram_port_use: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("ring read and write in the same cycle");
`endif

endmodule

// ===== rtl/deq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the double-ended queue: directed table, then random command runs.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import deq_pkg::*;

	localparam int CAPACITY      = 64;
	localparam int DIRECTED_ROWS = 24;
	localparam int RANDOM_ITEMS  = 436;

	// Command codes the block does not decode; each still gives one result item.
	localparam logic [2:0] CMD_RSVD5 = 3'd5;
	localparam logic [2:0] CMD_RSVD6 = 3'd6;
	localparam logic [2:0] CMD_RSVD7 = 3'd7;
	localparam logic [2:0] RESERVED_CMDS [3] = '{CMD_RSVD5, CMD_RSVD6, CMD_RSVD7};

	typedef struct packed {
		status_t     status;
		logic [31:0] dumped;
		logic [31:0] front;
		logic [31:0] rear;
		logic [6:0]  count;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [31:0] value;
		bit          typed;   // take the result below instead of the predicted one
		result_t     want;
	} stim_row_t;

	typedef enum {RX_STEADY, RX_RANDOM, RX_PERIODIC, RX_BLOCKY} rx_mode_t;

	localparam result_t NO_WANT = '{ST_OK, 32'h0, 32'h0, 32'h0, 7'd0, 1'b0};

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [31:0]  s_axis_tdata = '0;
	logic [2:0]   s_axis_tuser = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [103:0] m_axis_tdata;
	logic [1:0]   m_axis_tuser;
	logic         m_axis_tlast;

	logic [31:0]  deque_model [$];     // front at index 0
	result_t      pending_results [$]; // oldest expectation first
	int           fail_count = 0;
	int           items_sent = 0;
	int           burst_left = 0;
	bit           no_gaps = 1'b0;
	bit           tx_busy = 1'b0;

	rx_mode_t     rx_mode = RX_STEADY;
	int           rx_left = 0;
	int           stall_left = 0;

	// Directed table: empty corner cases, extreme words, wrap of the front pointer.
	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{CMD_POP_FRONT,  32'h0000_0000, 1'b1, '{ST_EMPTY, 32'h0, 32'h0, 32'h0, 7'd0, 1'b1}},
		'{CMD_POP_REAR,   32'hFFFF_FFFF, 1'b1, '{ST_EMPTY, 32'h0, 32'h0, 32'h0, 7'd0, 1'b1}},
		'{CMD_DUMP,       32'h0000_0000, 1'b1, '{ST_EMPTY, 32'h0, 32'h0, 32'h0, 7'd0, 1'b1}},
		'{CMD_RSVD7,      32'h8000_0000, 1'b1, '{ST_OK, 32'h0, 32'h0, 32'h0, 7'd0, 1'b1}},
		'{CMD_PUSH_REAR,  32'h8000_0000, 1'b1,
			'{ST_OK, 32'h0, 32'h8000_0000, 32'h8000_0000, 7'd1, 1'b1}},
		'{CMD_PUSH_FRONT, 32'h7FFF_FFFF, 1'b1,
			'{ST_OK, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 7'd2, 1'b1}},
		'{CMD_PUSH_REAR,  32'hFFFF_FFFF, 1'b1,
			'{ST_OK, 32'h0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 7'd3, 1'b1}},
		'{CMD_PUSH_FRONT, 32'h0000_0000, 1'b1,
			'{ST_OK, 32'h0, 32'h0000_0000, 32'hFFFF_FFFF, 7'd4, 1'b1}},
		'{CMD_DUMP,       32'h0000_0000, 1'b0, NO_WANT},
		'{CMD_RSVD5,      32'h1234_5678, 1'b1,
			'{ST_OK, 32'h0, 32'h0000_0000, 32'hFFFF_FFFF, 7'd4, 1'b1}},
		'{CMD_RSVD6,      32'hFFFF_FFFF, 1'b1,
			'{ST_OK, 32'h0, 32'h0000_0000, 32'hFFFF_FFFF, 7'd4, 1'b1}},
		'{CMD_POP_FRONT,  32'h0000_0000, 1'b1,
			'{ST_OK, 32'h0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 7'd3, 1'b1}},
		'{CMD_POP_REAR,   32'h0000_0000, 1'b1,
			'{ST_OK, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 7'd2, 1'b1}},
		'{CMD_PUSH_REAR,  32'h0000_0001, 1'b0, NO_WANT},
		'{CMD_POP_FRONT,  32'hDEAD_BEEF, 1'b0, NO_WANT},
		'{CMD_POP_REAR,   32'h0000_0000, 1'b0, NO_WANT},
		'{CMD_POP_REAR,   32'h0000_0000, 1'b0, NO_WANT},
		'{CMD_POP_FRONT,  32'h0000_0000, 1'b1, '{ST_EMPTY, 32'h0, 32'h0, 32'h0, 7'd0, 1'b1}},
		'{CMD_PUSH_FRONT, 32'h5555_5555, 1'b0, NO_WANT},
		'{CMD_PUSH_FRONT, 32'hAAAA_AAAA, 1'b0, NO_WANT},
		'{CMD_DUMP,       32'hFFFF_FFFF, 1'b0, NO_WANT},
		'{CMD_POP_FRONT,  32'h0000_0000, 1'b0, NO_WANT},
		'{CMD_POP_FRONT,  32'h0000_0000, 1'b0, NO_WANT},
		'{CMD_DUMP,       32'h0000_0000, 1'b1, '{ST_EMPTY, 32'h0, 32'h0, 32'h0, 7'd0, 1'b1}}
	};

	double_ended_queue #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #4 clk = ~clk;

	// Queue one expected result that shows the deque as it stands now.
	function automatic void queue_result(input status_t st, input logic [31:0] dumped,
			input logic last);
		result_t r;
		r.status = st;
		r.dumped = dumped;
		r.front  = (deque_model.size() != 0) ? deque_model[0] : 32'h0;
		r.rear   = (deque_model.size() != 0) ? deque_model[deque_model.size() - 1] : 32'h0;
		r.count  = 7'(deque_model.size());
		r.last   = last;
		pending_results.insert(pending_results.size(), r);
	endfunction

	// Apply one accepted command to the deque model and queue its results.
	function automatic void apply_command(input logic [2:0] cmd, input logic [31:0] word);
		status_t st;
		int      n;
		st = ST_OK;
		n  = deque_model.size();
		case (cmd)
			CMD_PUSH_FRONT: begin
				if (n >= CAPACITY) st = ST_FULL;
				else deque_model.insert(0, word);
			end
			CMD_PUSH_REAR: begin
				if (n >= CAPACITY) st = ST_FULL;
				else deque_model.insert(n, word);
			end
			CMD_POP_FRONT: begin
				if (n == 0) st = ST_EMPTY;
				else deque_model.delete(0);
			end
			CMD_POP_REAR: begin
				if (n == 0) st = ST_EMPTY;
				else deque_model.delete(n - 1);
			end
			CMD_DUMP: begin
				// Dump leaves the deque alone: one item per word, front to rear.
				if (n == 0) begin
					queue_result(ST_EMPTY, 32'h0, 1'b1);
				end else begin
					for (int i = 0; i < n; i++)
						queue_result(ST_OK, deque_model[i], i == n - 1);
				end
				return;
			end
			default: ;
		endcase
		queue_result(st, 32'h0, 1'b1);
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
		fail_count++;
	endtask

	// Result checker: compare each accepted result item with the oldest expectation.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result, dumped_value", m_axis_tdata[31:0], 32'h0);
			end else begin
				want = pending_results[0];
				pending_results.delete(0);
				if (m_axis_tuser != want.status)
					report_mismatch("status", 32'(m_axis_tuser), 32'(want.status));
				if (m_axis_tdata[31:0] != want.dumped)
					report_mismatch("dumped_value", m_axis_tdata[31:0], want.dumped);
				if (m_axis_tdata[63:32] != want.front)
					report_mismatch("front_value", m_axis_tdata[63:32], want.front);
				if (m_axis_tdata[95:64] != want.rear)
					report_mismatch("rear_value", m_axis_tdata[95:64], want.rear);
				if (m_axis_tdata[102:96] != want.count)
					report_mismatch("element_count", 32'(m_axis_tdata[102:96]),
						32'(want.count));
				if (m_axis_tlast != want.last)
					report_mismatch("last", 32'(m_axis_tlast), 32'(want.last));
			end
		end
	end

	// Receiver: switch between randomly chosen stall patterns.
	always @(negedge clk) begin
		bit rdy;
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(30, 200);
		end
		rx_left--;
		case (rx_mode)
			RX_STEADY:   rdy = 1'b1;
			RX_RANDOM:   rdy = 1'($urandom_range(0, 1));
			RX_PERIODIC: rdy = (rx_left % 3) != 0;
			default: begin
				// Mostly ready, with an occasional long stall.
				if (stall_left > 0) begin
					stall_left--;
					rdy = 1'b0;
				end else if ($urandom_range(0, 7) == 0) begin
					stall_left = $urandom_range(1, 16);
					rdy = 1'b0;
				end else begin
					rdy = 1'b1;
				end
			end
		endcase
		m_axis_tready <= rdy;
	end

	// Drop valid once; call at a falling edge.
	task automatic lower_valid();
		if (tx_busy) begin
			s_axis_tvalid <= 1'b0;
			tx_busy = 1'b0;
		end
	endtask

	// Offer one command item, predict at acceptance, then idle between bursts unless no_gaps is set.
	task automatic send_command(input logic [2:0] cmd, input logic [31:0] word,
			input bit typed, input result_t want);
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= word;
		s_axis_tvalid <= 1'b1;
		tx_busy = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		apply_command(cmd, word);
		if (typed) begin
			// Typed rows cause one result: swap in the hand-written one.
			pending_results[pending_results.size() - 1] = want;
		end
		items_sent++;
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 23);
			if (!no_gaps) begin
				lower_valid();
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
		end
	endtask

	// Hold the sender until every expected result has come out.
	task automatic hold_until_drained();
		lower_valid();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 9))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return 32'h0000_0000;
			3:       return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [2:0] pick_command();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30) return CMD_PUSH_FRONT;
		if (r < 60) return CMD_PUSH_REAR;
		if (r < 74) return CMD_POP_FRONT;
		if (r < 88) return CMD_POP_REAR;
		if (r < 95) return CMD_DUMP;
		return RESERVED_CMDS[$urandom_range(0, 2)];
	endfunction

	function automatic logic [2:0] pick_push();
		return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
	endfunction

	function automatic logic [2:0] pick_pop();
		return $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_REAR;
	endfunction

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++)
			send_command(directed_rows[i].cmd, directed_rows[i].value,
				directed_rows[i].typed, directed_rows[i].want);

		// Let the directed part drain before the random runs start.
		hold_until_drained();

		while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 9))
				4, 5: begin
					// Fill to capacity, push into the full deque, maybe dump it all.
					while (deque_model.size() < CAPACITY)
						send_command(pick_push(), pick_word(), 1'b0, NO_WANT);
					repeat ($urandom_range(1, 4))
						send_command(pick_push(), pick_word(), 1'b0, NO_WANT);
					if ($urandom_range(0, 1))
						send_command(CMD_DUMP, pick_word(), 1'b0, NO_WANT);
				end
				6, 7: begin
					// Drain from either end, then pop or dump the empty deque.
					while (deque_model.size() > 0)
						send_command(pick_pop(), pick_word(), 1'b0, NO_WANT);
					repeat ($urandom_range(1, 3))
						send_command($urandom_range(0, 2) ? pick_pop() : CMD_DUMP,
							pick_word(), 1'b0, NO_WANT);
				end
				8: begin
					send_command(CMD_DUMP, pick_word(), 1'b0, NO_WANT);
				end
				9: begin
					hold_until_drained();
					repeat ($urandom_range(4, 20))
						send_command(pick_command(), pick_word(), 1'b0, NO_WANT);
				end
				default: begin
					repeat ($urandom_range(8, 30))
						send_command(pick_command(), pick_word(), 1'b0, NO_WANT);
				end
			endcase
		end

		hold_until_drained();
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#20ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== double_ended_queue.f =====
rtl/deq_pkg.sv
rtl/deq_ram.sv
rtl/double_ended_queue.sv
sim/testbench.sv
